/* rtl/akngw_pkg.sv */
package akngw_pkg;

  // Angle scale: unsigned Q2.14 radians
  localparam logic [15:0] ANG_PI      = 16'd51472;
  localparam logic [15:0] ANG_HALF_PI = 16'd25736;

  // Integer part of the exponent at or above this gives a zero weight
  localparam logic [11:0] EXP_INT_LEN = 12'd12;

  // Configuration register indexes
  localparam logic CFG_BIDIR     = 1'b0;
  localparam logic CFG_INV_SIGMA = 1'b1;

  // Reset value of 1/(2 sigma^2), Q8.8
  localparam logic [15:0] INV_SIGMA_RESET = 16'd256;

  typedef struct packed {
    logic [15:0] angle;
    logic [5:0]  candidate_index;
    logic        is_self;
    logic        last_candidate;
  } in_t;

  typedef struct packed {
    logic [5:0]  neighbor_index;
    logic [15:0] weight;
    logic        last_out;
  } out_t;

  // Chain cell control
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctl_t;

  // Slot pulled off the head of the chain for weighting
  typedef struct packed {
    logic        valid;
    logic [15:0] angle;
    logic [5:0]  index;
    logic        last;
  } drain_t;

  // round(65536*exp(-n)), n = 0..11
  function automatic logic [16:0] exp_int(input logic [3:0] n);
    logic [16:0] r;
    case (n)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd24109;
      4'd2:    r = 17'd8869;
      4'd3:    r = 17'd3263;
      4'd4:    r = 17'd1200;
      4'd5:    r = 17'd442;
      4'd6:    r = 17'd162;
      4'd7:    r = 17'd60;
      4'd8:    r = 17'd22;
      4'd9:    r = 17'd8;
      4'd10:   r = 17'd3;
      4'd11:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // round(65536*exp(-h/16))
  function automatic logic [16:0] exp_hi(input logic [3:0] h);
    logic [16:0] r;
    case (h)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd61565;
      4'd2:    r = 17'd57835;
      4'd3:    r = 17'd54331;
      4'd4:    r = 17'd51039;
      4'd5:    r = 17'd47947;
      4'd6:    r = 17'd45042;
      4'd7:    r = 17'd42313;
      4'd8:    r = 17'd39750;
      4'd9:    r = 17'd37341;
      4'd10:   r = 17'd35079;
      4'd11:   r = 17'd32954;
      4'd12:   r = 17'd30957;
      4'd13:   r = 17'd29081;
      4'd14:   r = 17'd27319;
      4'd15:   r = 17'd25664;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // round(65536*exp(-l/256))
  function automatic logic [16:0] exp_lo(input logic [3:0] l);
    logic [16:0] r;
    case (l)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd65280;
      4'd2:    r = 17'd65026;
      4'd3:    r = 17'd64772;
      4'd4:    r = 17'd64520;
      4'd5:    r = 17'd64268;
      4'd6:    r = 17'd64018;
      4'd7:    r = 17'd63768;
      4'd8:    r = 17'd63520;
      4'd9:    r = 17'd63272;
      4'd10:   r = 17'd63025;
      4'd11:   r = 17'd62780;
      4'd12:   r = 17'd62535;
      4'd13:   r = 17'd62291;
      4'd14:   r = 17'd62048;
      4'd15:   r = 17'd61806;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/akngw_cell.sv */
module akngw_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  akngw_pkg::cell_ctl_t  ctl,
  input  logic [15:0]           cand_angle,
  input  logic [5:0]            cand_index,
  input  logic                  left_lt,
  input  logic [15:0]           left_angle,
  input  logic [5:0]            left_index,
  input  logic [15:0]           right_angle,
  input  logic [5:0]            right_index,
  output logic                  lt,
  output logic [15:0]           angle,
  output logic [5:0]            index
);
  import akngw_pkg::*;

  // Strictly less: equal angles land after existing entries
  assign lt = (cand_angle < angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= ANG_PI;
      index <= 6'd0;
    end else if (ctl.insert) begin
      if (left_lt) begin
        // candidate went in further up, move down one place
        angle <= left_angle;
        index <= left_index;
      end else if (lt) begin
        angle <= cand_angle;
        index <= cand_index;
      end
    end else if (ctl.shift) begin
      // drain toward the head
      angle <= right_angle;
      index <= right_index;
    end
  end

endmodule

/* rtl/akngw_weight.sv */
module akngw_weight (
  input  logic                  clk,
  input  logic                  rst,
  input  akngw_pkg::drain_t     push,
  input  logic [15:0]           inv_two_sigma_sq,
  input  logic                  out_ready,
  output logic                  adv,
  output logic                  out_valid,
  output akngw_pkg::out_t       out_item
);
  import akngw_pkg::*;

  logic        v1, v2, v3;
  logic [31:0] sq;
  logic [5:0]  idx1, idx2, idx3;
  logic        last1, last2, last3;
  logic [19:0] t2;
  logic [16:0] w3;
  logic [3:0]  lo3;
  logic        zero3;

  logic [48:0] x_rnd;
  logic [32:0] prod1;
  logic [33:0] prod1_rnd;
  logic [33:0] prod2;
  logic [34:0] prod2_rnd;
  logic [18:0] w_fin;
  logic [15:0] w_sat;

  // whole pipe moves only when the output register can take a new item
  assign adv = ~out_valid | out_ready;

  // exponent in 2^-8 units, rounded half up
  assign x_rnd = {17'd0, sq} * {33'd0, inv_two_sigma_sq} + (49'd1 << 27);

  assign prod1     = exp_int(t2[11:8]) * {16'd0, exp_hi(t2[7:4])};
  assign prod1_rnd = {1'b0, prod1} + 34'd32768;

  assign prod2     = {17'd0, w3} * {17'd0, exp_lo(lo3)};
  assign prod2_rnd = {1'b0, prod2} + 35'd32768;
  assign w_fin     = prod2_rnd[34:16];
  assign w_sat     = zero3 ? 16'd0 :
                     (w_fin > 19'd65535) ? 16'hFFFF : w_fin[15:0];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= push.valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // datapath: square, scale, integer*high table, low table
  always_ff @(posedge clk) begin
    if (adv) begin
      sq    <= {16'd0, push.angle} * {16'd0, push.angle};
      idx1  <= push.index;
      last1 <= push.last;

      t2    <= x_rnd[47:28];
      idx2  <= idx1;
      last2 <= last1;

      w3    <= prod1_rnd[32:16];
      lo3   <= t2[3:0];
      zero3 <= (t2[19:8] >= EXP_INT_LEN);
      idx3  <= idx2;
      last3 <= last2;

      out_item.neighbor_index <= idx3;
      out_item.weight         <= w_sat;
      out_item.last_out       <= last3;
    end
  end

endmodule

/* rtl/angular_k_nearest_gaussian_weights.sv */
// Keeps the NEIGHBORS smallest angles seen for one target in a chain of
// compare-and-shift cells and, after the item flagged last_candidate, emits
// NEIGHBORS results nearest first with Gaussian weights. Candidates are taken
// one per cycle. The last candidate is inserted, then the chain drains one
// slot per cycle, holding while the output stalls, into a four-stage weight
// pipeline, so in_ready is low until the last slot has left the chain. Unfilled
// slots report index 0 with the weight of pi. Register 0 is bidirectional,
// register 1 is 1/(2 sigma^2) in Q8.8; write them only while the block is
// idle.
module angular_k_nearest_gaussian_weights #(
  parameter int NEIGHBORS = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  akngw_pkg::in_t    in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output akngw_pkg::out_t   out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data
);
  import akngw_pkg::*;

  localparam int CW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(NEIGHBORS - 1);

  typedef enum logic {COLLECT, DRAIN} state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  logic          bidirectional;
  logic [15:0]   inv_two_sigma_sq;

  logic        in_acc;
  logic        adv;
  logic [15:0] a_sat;
  logic [15:0] cand_angle;
  cell_ctl_t   ctl;
  drain_t      push;

  logic [15:0] c_angle [NEIGHBORS];
  logic [5:0]  c_index [NEIGHBORS];
  logic        c_lt    [NEIGHBORS];

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == COLLECT);
  assign in_acc    = in_valid & in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bidirectional    <= 1'b0;
      inv_two_sigma_sq <= INV_SIGMA_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BIDIR:     bidirectional    <= cfg_data[0];
        CFG_INV_SIGMA: inv_two_sigma_sq <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Candidate angle: saturate at pi, optional fold, self forced to pi
  assign a_sat = (in_item.angle > ANG_PI) ? ANG_PI : in_item.angle;
  always_comb begin
    if (in_item.is_self) begin
      cand_angle = ANG_PI;
    end else if (bidirectional && (a_sat > ANG_HALF_PI)) begin
      cand_angle = ANG_PI - a_sat;
    end else begin
      cand_angle = a_sat;
    end
  end

  assign ctl.insert = in_acc;
  assign ctl.shift  = (state == DRAIN) & adv;

  // Head of the chain feeds the weight pipe during the drain
  assign push.valid = ctl.shift;
  assign push.angle = c_angle[0];
  assign push.index = c_index[0];
  assign push.last  = (cnt == CNT_LAST);

  // Collect / drain sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= COLLECT;
      cnt   <= '0;
    end else begin
      case (state)
        COLLECT: begin
          cnt <= '0;
          if (in_acc && in_item.last_candidate) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (adv) begin
            if (cnt == CNT_LAST) begin
              state <= COLLECT;
              cnt   <= '0;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: state <= COLLECT;
      endcase
    end
  end

  // Sorted slot chain
  for (genvar i = 0; i < NEIGHBORS; i++) begin : g_cell
    logic        l_lt;
    logic [15:0] l_angle, r_angle;
    logic [5:0]  l_index, r_index;

    if (i == 0) begin : g_head
      assign l_lt    = 1'b0;
      assign l_angle = ANG_PI;
      assign l_index = 6'd0;
    end else begin : g_body
      assign l_lt    = c_lt[i-1];
      assign l_angle = c_angle[i-1];
      assign l_index = c_index[i-1];
    end

    if (i == NEIGHBORS - 1) begin : g_tail
      assign r_angle = ANG_PI;
      assign r_index = 6'd0;
    end else begin : g_next
      assign r_angle = c_angle[i+1];
      assign r_index = c_index[i+1];
    end

    akngw_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .cand_angle  (cand_angle),
      .cand_index  (in_item.candidate_index),
      .left_lt     (l_lt),
      .left_angle  (l_angle),
      .left_index  (l_index),
      .right_angle (r_angle),
      .right_index (r_index),
      .lt          (c_lt[i]),
      .angle       (c_angle[i]),
      .index       (c_index[i])
    );
  end

  akngw_weight u_weight (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .inv_two_sigma_sq (inv_two_sigma_sq),
    .out_ready        (out_ready),
    .adv              (adv),
    .out_valid        (out_valid),
    .out_item         (out_item)
  );

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import akngw_pkg::*;

  localparam int NEIGH      = 6;
  localparam int TAIL       = 12;      // quiet tail after the last due result
  localparam int LIMIT      = 400000;
  localparam int MAX_GAP    = 18;
  localparam int RAND_ITEMS = 100;
  localparam int MAX_PRINTS = 60;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_t         in_item;
  logic        out_valid;
  logic        out_ready;
  out_t        out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  angular_k_nearest_gaussian_weights DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // exp tables: round(65536*exp(-v)) for v = n, h/16, l/256
  int unsigned exp_whole_tbl [12] = '{65536, 24109, 8869, 3263, 1200, 442,
                                      162, 60, 22, 8, 3, 1};
  int unsigned exp_sixteenth_tbl [16] = '{65536, 61565, 57835, 54331, 51039, 47947,
                                          45042, 42313, 39750, 37341, 35079, 32954,
                                          30957, 29081, 27319, 25664};
  int unsigned exp_fine_tbl [16] = '{65536, 65280, 65026, 64772, 64520, 64268,
                                     64018, 63768, 63520, 63272, 63025, 62780,
                                     62535, 62291, 62048, 61806};

  // Shadow of the block: registers and the sorted neighbor list
  logic        bidir_reg;
  logic [15:0] sigma_reg;
  logic [15:0] slot_ang [NEIGH];
  logic [5:0]  slot_idx [NEIGH];

  out_t expected_neighbors [$];

  int   errors;
  int   cycles;
  int   n_items;
  int   n_targets;
  int   n_results;
  int   n_writes;
  int   rx_stall;
  int   rx_draw;
  logic no_idle;
  logic [15:0] prev_angle;

  // Cycle counter and run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               expected_neighbors.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("MISMATCH cycle %0d: %s", cycles, msg);
  endtask

  function automatic int draw_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [15:0] gauss_weight(input logic [15:0] a);
    logic [63:0] x;
    logic [63:0] t;
    logic [63:0] w;
    x = {48'd0, a} * {48'd0, a} * {48'd0, sigma_reg};
    t = (x + (64'd1 << 27)) >> 28;
    if ((t >> 8) >= 64'd12) return 16'd0;
    w = 64'(exp_whole_tbl[t[11:8]]);
    w = (w * 64'(exp_sixteenth_tbl[t[7:4]]) + 64'd32768) >> 16;
    w = (w * 64'(exp_fine_tbl[t[3:0]]) + 64'd32768) >> 16;
    if (w > 64'd65535) w = 64'd65535;
    return w[15:0];
  endfunction

  task automatic clear_slots();
    for (int i = 0; i < NEIGH; i++) begin
      slot_ang[i] = ANG_PI;
      slot_idx[i] = 6'd0;
    end
  endtask

  // Saturate and fold (self forced to pi), insert after equal angles, and on the last candidate queue the emit
  task automatic predict_candidate(input in_t it);
    logic [15:0] a;
    int          pos;
    out_t        r;
    a = it.angle;
    if (it.is_self) begin
      a = ANG_PI;
    end else begin
      if (a > ANG_PI) a = ANG_PI;
      if (bidir_reg && a > ANG_HALF_PI) a = ANG_PI - a;
    end
    pos = NEIGH;
    for (int i = NEIGH - 1; i >= 0; i--)
      if (a < slot_ang[i]) pos = i;
    if (pos < NEIGH) begin
      for (int q = NEIGH - 1; q > pos; q--) begin
        slot_ang[q] = slot_ang[q - 1];
        slot_idx[q] = slot_idx[q - 1];
      end
      slot_ang[pos] = a;
      slot_idx[pos] = it.candidate_index;
    end
    if (it.last_candidate) begin
      for (int k = 0; k < NEIGH; k++) begin
        r.neighbor_index = slot_idx[k];
        r.weight         = gauss_weight(slot_ang[k]);
        r.last_out       = (k == NEIGH - 1);
        expected_neighbors.insert(expected_neighbors.size(), r);
      end
      clear_slots();
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (expected_neighbors.size() == 0) begin
      report_mismatch($sformatf("unexpected result index %0d weight %0d last %0b",
                                got.neighbor_index, got.weight, got.last_out));
      return;
    end
    want = expected_neighbors.pop_front();
    n_results++;
    if (got.neighbor_index !== want.neighbor_index)
      report_mismatch($sformatf("neighbor_index got %0d want %0d",
                                got.neighbor_index, want.neighbor_index));
    if (got.weight !== want.weight)
      report_mismatch($sformatf("weight got %0d want %0d (index %0d)",
                                got.weight, want.weight, want.neighbor_index));
    if (got.last_out !== want.last_out)
      report_mismatch($sformatf("last_out got %0b want %0b",
                                got.last_out, want.last_out));
  endtask

  // Result side: check each accepted item, then maybe stall a random number of cycles
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        check_result(out_item);
        rx_draw = draw_gap();
        if (rx_draw != 0) begin
          out_ready <= 1'b0;
          rx_stall  <= rx_draw - 1;
        end
      end else if (!out_ready) begin
        if (rx_stall == 0) out_ready <= 1'b1;
        else rx_stall <= rx_stall - 1;
      end
    end
  end

  // One candidate: hold until accepted, then maybe idle before the next one
  task automatic send_candidate(input logic [15:0] ang, input logic [5:0] idx,
                                input logic self_f, input logic last_f);
    in_t it;
    int  gap;
    it.angle           = ang;
    it.candidate_index = idx;
    it.is_self         = self_f;
    it.last_candidate  = last_f;
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_candidate(it);
    n_items++;
    if (last_f) n_targets++;
    prev_angle = ang;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every due result, then a tail of quiet cycles
  task automatic wait_drained(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_neighbors.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Both registers, back to back on the config channel
  task automatic write_config(input logic bidir_v, input logic [15:0] sigma_v);
    cfg_index <= CFG_BIDIR;
    cfg_data  <= {15'd0, bidir_v};
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    bidir_reg = bidir_v;
    cfg_index <= CFG_INV_SIGMA;
    cfg_data  <= sigma_v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sigma_reg = sigma_v;
    cfg_valid <= 1'b0;
    n_writes += 2;
  endtask

  function automatic logic [15:0] pick_angle();
    logic [15:0] r;
    case ($urandom_range(0, 6))
      0:       r = 16'($urandom_range(0, 65535));
      1:       r = 16'($urandom_range(0, 2000));
      2:       r = 16'($urandom_range(51000, 65535));
      3:       r = 16'($urandom_range(25700, 25780));
      4:       r = prev_angle;
      default: r = 16'($urandom_range(0, 51472));
    endcase
    return r;
  endfunction

  // Reset state: one last candidate, five slots still unfilled
  task automatic test_reset_state();
    send_candidate(16'd8192, 6'd5, 1'b0, 1'b1);
  endtask

  // Extremes of angle and index, pi and above, self, ties, and overflow of the list
  task automatic test_insertion_order();
    wait_drained(TAIL);
    write_config(1'b0, INV_SIGMA_RESET);
    send_candidate(16'd0,     6'd63, 1'b0, 1'b0);
    send_candidate(16'hFFFF,  6'd1,  1'b0, 1'b0);
    send_candidate(ANG_PI,    6'd2,  1'b0, 1'b0);
    send_candidate(16'd0,     6'd3,  1'b1, 1'b0);
    send_candidate(16'd100,   6'd4,  1'b0, 1'b0);
    send_candidate(16'd100,   6'd5,  1'b0, 1'b0);
    send_candidate(16'd51471, 6'd6,  1'b0, 1'b0);
    send_candidate(16'd1,     6'd7,  1'b0, 1'b1);
    // descending angles push older entries toward the end
    for (int i = 0; i < 6; i++)
      send_candidate(16'(30000 - i * 4000), 6'(40 + i), 1'b0, 1'b0);
    send_candidate(16'd65535, 6'd0, 1'b1, 1'b1);
  endtask

  task automatic test_bidirectional_fold();
    wait_drained(TAIL);
    write_config(1'b1, INV_SIGMA_RESET);
    send_candidate(ANG_HALF_PI,         6'd10, 1'b0, 1'b0);
    send_candidate(ANG_HALF_PI + 16'd1, 6'd11, 1'b0, 1'b0);
    send_candidate(ANG_PI,              6'd12, 1'b0, 1'b0);
    send_candidate(16'hFFFF,            6'd13, 1'b0, 1'b0);
    send_candidate(16'd0,               6'd14, 1'b1, 1'b0);
    send_candidate(16'd40000,           6'd15, 1'b0, 1'b1);
  endtask

  task automatic test_sigma_extremes();
    wait_drained(TAIL);
    write_config(1'b0, 16'd0);
    send_candidate(ANG_PI,    6'd1, 1'b0, 1'b0);
    send_candidate(16'd12345, 6'd42, 1'b0, 1'b1);
    wait_drained(TAIL);
    write_config(1'b1, 16'hFFFF);
    send_candidate(16'd1,       6'd2,  1'b0, 1'b0);
    send_candidate(ANG_HALF_PI, 6'd21, 1'b0, 1'b1);
  endtask

  task automatic run_random_target();
    int len;
    len = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 10);
    no_idle = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++)
      send_candidate(pick_angle(), 6'($urandom_range(0, 63)),
                     ($urandom_range(0, 7) == 0), (i == len - 1));
  endtask

  task automatic test_random_targets();
    int          goal;
    logic [15:0] sig;
    goal = n_items + RAND_ITEMS;
    while (n_items < goal) begin
      case ($urandom_range(0, 5))
        0: begin
          case ($urandom_range(0, 5))
            0:       sig = 16'd0;
            1:       sig = 16'hFFFF;
            2:       sig = INV_SIGMA_RESET;
            3:       sig = 16'($urandom_range(0, 65535));
            default: sig = 16'($urandom_range(1, 4096));
          endcase
          wait_drained(TAIL);
          write_config(1'($urandom_range(0, 1)), sig);
        end
        1: wait_drained(0);   // let the whole emit finish before more candidates
        default: ;
      endcase
      run_random_target();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_item    = '0;
    out_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_BIDIR;
    cfg_data   = 16'd0;
    errors     = 0;
    cycles     = 0;
    n_items    = 0;
    n_targets  = 0;
    n_results  = 0;
    n_writes   = 0;
    rx_stall   = 0;
    no_idle    = 1'b0;
    prev_angle = 16'd0;
    bidir_reg  = 1'b0;
    sigma_reg  = INV_SIGMA_RESET;
    clear_slots();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_insertion_order();
    test_bidirectional_fold();
    test_sigma_extremes();
    test_random_targets();

    wait_drained(TAIL);
    if (expected_neighbors.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_neighbors.size()));
    $display("run: %0d candidates over %0d targets, %0d neighbor results checked",
             n_items, n_targets, n_results);
    $display("run: %0d register writes, fold on and off, sigma 0 through 65535, %0d errors",
             n_writes, errors);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
